/* sv/assert_macros.svh */
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked every cycle outside reset
`define AST_IMPL(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
// Next-cycle implication outside reset
`define AST_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`endif

/* sv/ewtt_pkg.sv */
// ----------------------------------------------------------------------------
// ewtt_pkg
// Shared constants for the edge weighted tile threshold block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ewtt_pkg;
  localparam int MaxTileSide = 64;
  localparam int StoreDepth  = MaxTileSide * MaxTileSide;
  localparam int AddrW       = $clog2(StoreDepth);
  localparam int SideW       = $clog2(MaxTileSide + 1);
  localparam int CntW        = AddrW + 1;
  localparam int WsumW       = 28;
  localparam int EsumW       = 20;
  localparam int CfgW        = 20;
  localparam logic [WsumW-1:0] WsumMax = '1;
  localparam logic [EsumW-1:0] EsumMax = '1;
  localparam logic [7:0] PixOn = 8'd255;
  localparam logic [7:0] PixOff = 8'd0;
  localparam logic [1:0] RegWidth  = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegMinThr = 2'd2;
  localparam logic [1:0] RegGate   = 2'd3;
  localparam logic OpLoad  = 1'b0;
  localparam logic OpFetch = 1'b1;
endpackage

/* sv/ewtt_if.sv */
// ----------------------------------------------------------------------------
// ewtt_in_if / ewtt_out_if
// Valid/ready channels for input items and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface ewtt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] pixel;
  modport source (output valid, op, pixel, input ready);
  modport sink (input valid, op, pixel, output ready);
endinterface

interface ewtt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_pixel;
  logic [7:0] tile_threshold;
  logic       edges_exceed;
  logic       last;
  modport source (output valid, out_pixel, tile_threshold, edges_exceed, last,
                  input ready);
  modport sink (input valid, out_pixel, tile_threshold, edges_exceed, last,
                output ready);
endinterface

/* sv/ewtt_div.sv */
// ----------------------------------------------------------------------------
// ewtt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ewtt_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ewtt_pkg::WsumW-1:0] dividend,
  input  logic [ewtt_pkg::EsumW-1:0] divisor,
  output logic                      done,
  output logic [ewtt_pkg::WsumW-1:0] quot
);
  import ewtt_pkg::*;
  localparam int StepW = $clog2(WsumW + 1);

  logic             busy;
  logic [StepW-1:0] step;
  logic [EsumW:0]   rem;
  logic [EsumW-1:0] dvs;
  logic [EsumW+1:0] trial;
  logic [EsumW:0]   shifted;

  always_comb begin
    shifted = {rem[EsumW-1:0], quot[WsumW-1]};
    trial   = {1'b0, shifted} - {2'b00, dvs};
  end

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (step == StepW'(1));
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= StepW'(WsumW);
      rem  <= '0;
      quot <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (trial[EsumW+1]) begin
        rem  <= shifted;
        quot <= {quot[WsumW-2:0], 1'b0};
      end else begin
        rem  <= trial[EsumW:0];
        quot <= {quot[WsumW-2:0], 1'b1};
      end
      step <= step - 1'b1;
      if (step == StepW'(1)) busy <= 1'b0;
    end
  end
endmodule

/* sv/edge_weighted_tile_threshold.sv */
// ----------------------------------------------------------------------------
// edge_weighted_tile_threshold
// Edge weighted mean threshold binarizer for one gray tile.
// ----------------------------------------------------------------------------
// Usage: input channel carries op and pixel. A load transaction (op 0)
// stores the next pixel in raster order; loads are taken back to back.
// After the last pixel the block runs a gradient pass over the tile store;
// for each pixel it makes five reads of the single store read port, waits
// for the last read data and accumulates, and at the end runs a divide.
// No input is taken during this pass.
// A fetch transaction (op 1) returns one binarized pixel, with the tile
// threshold, the edge gate flag and last. The result passes the S_FRD
// state and then the output register before it is valid.
// Loads on a finished tile and fetches before the tile is finished are
// taken and dropped. A stalled receiver holds the result register; the
// block accepts no further fetch until it is taken, while loads of the
// next tile still proceed.
// Reset (synchronous, rst high) clears counters and sums; the tile store
// is not cleared and needs no clearing pass. Writing width or height
// abandons the current tile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module edge_weighted_tile_threshold (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [1:0]                cfg_index,
  input  logic [ewtt_pkg::CfgW-1:0] cfg_data,
  ewtt_in_if.sink                   in_ch,
  ewtt_out_if.source                out_ch
);
  import ewtt_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {S_LOAD, S_GRAD, S_MAC, S_DIV, S_READY, S_FRD}
    state_t;

  state_t           state;
  logic [6:0]       tile_width, tile_height;
  logic [7:0]       min_threshold;
  logic [EsumW-1:0] edge_gate;

  logic [7:0]       mem [StoreDepth];
  logic [7:0]       rd_data;
  logic [AddrW-1:0] rd_addr;
  logic [CntW-1:0]  load_count, fetch_count;
  logic [WsumW-1:0] weighted_sum;
  logic [EsumW-1:0] edge_sum;
  logic [7:0]       threshold_reg;

  logic [SideW-1:0] w, h;
  logic [CntW-1:0]  n;
  logic [SideW-1:0] row, col;
  logic [AddrW-1:0] base;
  logic [2:0]       phase;
  logic [7:0]       p_up, p_dn, p_lf, p_rt;
  logic [7:0]       e_val;
  logic [15:0]      prod;
  logic             div_start, div_done;
  logic [WsumW-1:0] div_q;

  function automatic logic [SideW-1:0] clamp_side(input logic [6:0] v);
    if (v < 7'd3) return SideW'(3);
    if (v > 7'(MaxTileSide)) return SideW'(MaxTileSide);
    return SideW'(v);
  endfunction

  function automatic logic [7:0] absd(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign w = clamp_side(tile_width);
  assign h = clamp_side(tile_height);
  assign n = CntW'(w * h);

  wire in_fire  = in_ch.valid && in_ch.ready;
  wire out_fire = out_ch.valid && out_ch.ready;
  wire top_b    = (row == '0) || (row == h - 1'b1);
  wire side_b   = (col == '0) || (col == w - 1'b1);
  wire mac_last = (col == w - 1'b1) && (row == h - 1'b1);
  wire size_wr  = cfg_we && (cfg_index inside {RegWidth, RegHeight});

  assign in_ch.ready = (state == S_LOAD) || (state == S_READY && !out_ch.valid);

  always_comb begin
    case (phase)
      3'd0:    rd_addr = AddrW'(base - AddrW'(w));
      3'd1:    rd_addr = AddrW'(base + AddrW'(w));
      3'd2:    rd_addr = AddrW'(base - 1'b1);
      3'd3:    rd_addr = AddrW'(base + 1'b1);
      default: rd_addr = base;
    endcase
    if (state == S_READY) rd_addr = fetch_count[AddrW-1:0];
  end

  always_ff @(posedge clk) begin
    if (state == S_LOAD && in_fire && in_ch.op == OpLoad)
      mem[load_count[AddrW-1:0]] <= in_ch.pixel;
    rd_data <= mem[rd_addr];
  end

  always_comb begin
    logic [7:0] v, hz;
    v  = top_b  ? 8'd0 : absd(p_up, p_dn);
    hz = side_b ? 8'd0 : absd(p_lf, p_rt);
    e_val = (v > hz) ? v : hz;
  end

  ewtt_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(weighted_sum),
    .divisor(edge_sum), .done(div_done), .quot(div_q)
  );

  always_ff @(posedge clk) begin
    div_start <= !rst && !size_wr && (state == S_MAC) && mac_last;
    if (rst) begin
      state <= S_LOAD;
      tile_width <= 7'd16; tile_height <= 7'd16;
      min_threshold <= 8'd15; edge_gate <= EsumW'(1500);
      load_count <= '0; fetch_count <= '0;
      weighted_sum <= '0; edge_sum <= '0; threshold_reg <= '0;
      out_ch.valid <= 1'b0;
      row <= '0; col <= '0; base <= '0; phase <= '0;
    end else if (size_wr) begin
      if (cfg_index == RegWidth) tile_width <= cfg_data[6:0];
      else tile_height <= cfg_data[6:0];
      load_count <= '0; fetch_count <= '0;
      weighted_sum <= '0; edge_sum <= '0; threshold_reg <= '0;
      state <= S_LOAD;
      if (out_fire) out_ch.valid <= 1'b0;
    end else begin
      if (state == S_FRD) out_ch.valid <= 1'b1;
      else if (out_fire) out_ch.valid <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          RegMinThr: min_threshold <= cfg_data[7:0];
          RegGate:   edge_gate <= cfg_data[EsumW-1:0];
          default: ;
        endcase
      end
      case (state)
        S_LOAD: begin
          if (in_fire && in_ch.op == OpLoad) begin
            load_count <= load_count + 1'b1;
            if (load_count + 1'b1 >= n) begin
              state <= S_GRAD;
              row <= '0; col <= '0; base <= '0; phase <= '0;
            end
          end
        end
        S_GRAD: begin
          // phase k reads address k; data of phase k-1 arrives now
          case (phase)
            3'd1: p_up <= rd_data;
            3'd2: p_dn <= rd_data;
            3'd3: p_lf <= rd_data;
            3'd4: p_rt <= rd_data;
            default: ;
          endcase
          if (phase == 3'd5) begin
            prod  <= {8'd0, rd_data} * {8'd0, e_val};
            state <= S_MAC;
          end else begin
            phase <= phase + 1'b1;
          end
        end
        S_MAC: begin
          logic [WsumW:0] ws;
          logic [EsumW:0] es;
          ws = {1'b0, weighted_sum} + (WsumW+1)'(prod);
          es = {1'b0, edge_sum} + (EsumW+1)'(e_val);
          weighted_sum <= ws[WsumW] ? WsumMax : ws[WsumW-1:0];
          edge_sum <= es[EsumW] ? EsumMax : es[EsumW-1:0];
          phase <= '0;
          base <= base + 1'b1;
          if (col == w - 1'b1) begin
            col <= '0;
            row <= row + 1'b1;
          end else begin
            col <= col + 1'b1;
          end
          state <= mac_last ? S_DIV : S_GRAD;
        end
        S_DIV: begin
          if (div_done) begin
            if (edge_sum == '0) threshold_reg <= min_threshold;
            else if (div_q > WsumW'(255)) threshold_reg <= 8'd255;
            else if (div_q[7:0] < min_threshold) threshold_reg <= min_threshold;
            else threshold_reg <= div_q[7:0];
            fetch_count <= '0;
            state <= S_READY;
          end
        end
        S_READY: begin
          if (in_fire && in_ch.op == OpFetch) state <= S_FRD;
        end
        S_FRD: begin
          out_ch.out_pixel <= (rd_data > threshold_reg) ? PixOn : PixOff;
          out_ch.tile_threshold <= threshold_reg;
          out_ch.edges_exceed <= edge_sum > edge_gate;
          out_ch.last <= fetch_count + 1'b1 >= n;
          if (fetch_count + 1'b1 >= n) begin
            load_count <= '0; fetch_count <= '0;
            weighted_sum <= '0; edge_sum <= '0; threshold_reg <= '0;
            state <= S_LOAD;
          end else begin
            fetch_count <= fetch_count + 1'b1;
            state <= S_READY;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `AST_IMPL(a_rdy_out, clk, rst, out_ch.valid && state != S_LOAD, !in_ch.ready)
  `AST_IMPL(a_cnt, clk, rst, state == S_LOAD, load_count < n)
  `AST_NEXT(a_frd, clk, rst, state == S_FRD && !cfg_we, out_ch.valid)
endmodule
